// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the bias calibration rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define IBC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define IBC_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define IBC_ASSERT(label, clk, rst_n, prop)

`define IBC_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ----- rtl/core/ibc_pkg.sv -----
// types, constants and arithmetic helpers for the imu bias calibration unit
// no dependencies; imported by every rtl module of the block
`default_nettype none

package ibc_pkg;

  localparam int SAMPLE_W = 24;
  localparam int CHANGE_W = 26;
  localparam int CNT_W    = 6;
  localparam int AXES     = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SAMPLE_W:0]   wide_t;
  typedef logic        [SAMPLE_W-1:0] mag_t;
  typedef logic        [CHANGE_W-1:0] change_t;
  typedef logic        [CNT_W-1:0]    cnt_t;

  localparam cnt_t SMOOTH_COUNT = 6'd50;
  localparam cnt_t WARMUP_COUNT = 6'd25;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // 500.0 and 9.805 in q11.12
  localparam sample_t PRESET_Q  = 24'sd2048000;
  localparam sample_t GRAVITY_Q = 24'sd40161;

  // smoothing gains: 0.9 and 0.1 in q0.15, half lsb rounding
  localparam int KEEP_GAIN  = 29491;
  localparam int NEW_GAIN   = 3277;
  localparam int ROUND_BIAS = 16384;
  localparam int GAIN_SHIFT = 15;
  localparam int PROD_W     = SAMPLE_W + 18;

  typedef logic signed [PROD_W-1:0] prod_t;

  // item opcode
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_START  = 1'b1
  } op_e;

  // limit register indexes
  typedef enum logic [1:0] {
    CFG_GYRO_CHANGE  = 2'd0,
    CFG_GYRO_OFFSET  = 2'd1,
    CFG_ACCEL_CHANGE = 2'd2,
    CFG_ACCEL_OFFSET = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic run;
    logic seed;
    logic filt;
    logic sel_accel;
    logic grav;
    logic diff;
    logic preset_gyro;
    logic preset_accel;
  } lane_ctrl_t;

  typedef struct packed {
    logic [1:0]                phase;
    sample_t [AXES-1:0]        gyro;
    sample_t [AXES-1:0]        accel;
    sample_t [AXES-1:0]        smooth;
  } result_t;

  function automatic sample_t ibc_sat(wide_t v);
    sample_t r;
    if (v[SAMPLE_W] != v[SAMPLE_W-1]) begin
      r = v[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  // cal*0.9 + x*0.1, rounded; the result stays inside the sample range
  function automatic sample_t ibc_smooth(sample_t cal, sample_t x);
    prod_t p_keep;
    prod_t p_new;
    prod_t acc;
    p_keep = PROD_W'(cal) * PROD_W'(KEEP_GAIN);
    p_new  = PROD_W'(x) * PROD_W'(NEW_GAIN);
    acc    = p_keep + p_new + PROD_W'(ROUND_BIAS);
    return SAMPLE_W'(acc >>> GAIN_SHIFT);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ibc_lane.sv -----
// one axis lane: gyro and accel offsets, smoothing filter, correction
// and round change for a single axis; uses ibc_pkg
`default_nettype none

module ibc_lane
  import ibc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lane_ctrl_t ctrl_i,
  input  sample_t    gyro_i,
  input  sample_t    accel_i,
  output sample_t    corr_gyro_o,
  output sample_t    corr_accel_o,
  output sample_t    smooth_o,
  output sample_t    offset_o,
  output mag_t       abs_diff_o
);

  sample_t gyro_off_q, gyro_off_d;
  sample_t accel_off_q, accel_off_d;
  sample_t start_q, start_d;
  sample_t filt_q, filt_d;
  mag_t    absd_q, absd_d;

  sample_t act_off;
  sample_t act_x;
  sample_t smooth_val;
  sample_t grav_val;
  sample_t corr_gyro;
  sample_t corr_accel;
  wide_t   diff;
  wide_t   avg_sum;

  assign act_off    = ctrl_i.sel_accel ? accel_off_q : gyro_off_q;
  assign act_x      = ctrl_i.sel_accel ? accel_i : gyro_i;
  assign smooth_val = ibc_smooth(act_off, act_x);
  assign grav_val   = ibc_sat(wide_t'(accel_off_q) + wide_t'(GRAVITY_Q));

  assign corr_gyro  = ibc_sat(wide_t'(gyro_i) - wide_t'(gyro_off_q));
  assign corr_accel = ibc_sat(wide_t'(accel_i) - wide_t'(accel_off_q));
  assign avg_sum    = wide_t'(filt_q) + wide_t'(corr_accel);

  assign diff   = wide_t'(start_q) - wide_t'(act_off);
  assign absd_d = ctrl_i.diff ? (diff[SAMPLE_W] ? SAMPLE_W'(-diff) : SAMPLE_W'(diff)) : absd_q;

  always_comb begin
    gyro_off_d = gyro_off_q;
    priority if (ctrl_i.preset_gyro) begin
      gyro_off_d = PRESET_Q;
    end else if (ctrl_i.seed && !ctrl_i.sel_accel) begin
      gyro_off_d = gyro_i;
    end else if (ctrl_i.filt && !ctrl_i.sel_accel) begin
      gyro_off_d = smooth_val;
    end else begin
      gyro_off_d = gyro_off_q;
    end
  end

  always_comb begin
    accel_off_d = accel_off_q;
    priority if (ctrl_i.preset_accel) begin
      accel_off_d = PRESET_Q;
    end else if (ctrl_i.seed && ctrl_i.sel_accel) begin
      accel_off_d = accel_i;
    end else if (ctrl_i.filt && ctrl_i.sel_accel) begin
      accel_off_d = smooth_val;
    end else if (ctrl_i.grav) begin
      accel_off_d = grav_val;
    end else begin
      accel_off_d = accel_off_q;
    end
  end

  assign start_d = ctrl_i.seed ? act_off : start_q;
  // two-point average, arithmetic shift by one
  assign filt_d  = ctrl_i.run ? avg_sum[SAMPLE_W:1] : filt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_off_q  <= '0;
      accel_off_q <= '0;
      start_q     <= '0;
      filt_q      <= '0;
      absd_q      <= '0;
    end else begin
      gyro_off_q  <= gyro_off_d;
      accel_off_q <= accel_off_d;
      start_q     <= start_d;
      filt_q      <= filt_d;
      absd_q      <= absd_d;
    end
  end

  assign corr_gyro_o  = ctrl_i.run ? corr_gyro : '0;
  assign corr_accel_o = ctrl_i.run ? corr_accel : '0;
  assign smooth_o     = filt_d;
  assign offset_o     = act_off;
  assign abs_diff_o   = absd_q;

endmodule

`default_nettype wire

// ----- rtl/core/ibc_merge.sv -----
// merging stage: sums the lane offset changes and finds the largest offset,
// then checks both against the round limits; uses ibc_pkg
`default_nettype none

module ibc_merge
  import ibc_pkg::*;
(
  input  logic    clk_i,
  input  logic    capture_i,
  input  mag_t    abs_diff_i [AXES],
  input  sample_t offset_i [AXES],
  input  change_t change_lim_i,
  input  sample_t offset_lim_i,
  output logic    settled_o
);

  sample_t mx_q, mx_d;
  sample_t mx01;
  change_t change_sum;

  assign mx01 = (offset_i[1] > offset_i[0]) ? offset_i[1] : offset_i[0];
  assign mx_d = capture_i ? ((offset_i[2] > mx01) ? offset_i[2] : mx01) : mx_q;

  always_ff @(posedge clk_i) begin
    mx_q <= mx_d;
  end

  assign change_sum = CHANGE_W'(abs_diff_i[0]) + CHANGE_W'(abs_diff_i[1])
                    + CHANGE_W'(abs_diff_i[2]);

  assign settled_o = (change_sum <= change_lim_i) && (mx_q <= offset_lim_i);

endmodule

`default_nettype wire

// ----- rtl/core/ibc_out_buf.sv -----
// two-entry result buffer: output register plus skid register
// uses ibc_pkg for the result type and assert_macros.svh for checks
`default_nettype none

`include "assert_macros.svh"

module ibc_out_buf
  import ibc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  input  logic    stall_i,
  output logic    valid_o,
  output logic    full_o,
  output result_t data_o
);

  logic    head_v_q, head_v_d;
  logic    skid_v_q, skid_v_d;
  result_t head_q, head_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop = head_v_q && !stall_i;

  always_comb begin
    head_v_d = head_v_q;
    skid_v_d = skid_v_q;
    head_d   = head_q;
    skid_d   = skid_q;
    unique case ({push_i, pop})
      2'b11: begin
        if (skid_v_q) begin
          head_d = skid_q;
          skid_d = data_i;
        end else begin
          head_d = data_i;
        end
      end
      2'b10: begin
        if (!head_v_q) begin
          head_d   = data_i;
          head_v_d = 1'b1;
        end else begin
          skid_d   = data_i;
          skid_v_d = 1'b1;
        end
      end
      2'b01: begin
        if (skid_v_q) begin
          head_d   = skid_q;
          skid_v_d = 1'b0;
        end else begin
          head_v_d = 1'b0;
        end
      end
      default: begin
        head_d = head_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      head_v_q <= head_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign valid_o = head_v_q;
  assign full_o  = skid_v_q;
  assign data_o  = head_q;

  `IBC_ASSERT_NEVER(a_no_overrun, clk_i, rst_ni, push_i && skid_v_q && !pop)
  `IBC_ASSERT(a_skid_behind_head, clk_i, rst_ni, skid_v_q |-> head_v_q)

endmodule

`default_nettype wire

// ----- rtl/core/imu_bias_calibration_and_correction_unit.sv -----
// top level of the imu bias calibration and correction unit
// uses ibc_pkg, ibc_lane, ibc_merge, ibc_out_buf and assert_macros.svh
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one six-axis sample or a
//   start command (op_i high). Output channel (out_valid_o / out_stall_i)
//   returns exactly one result item per input item, in order.
//   Configuration: cfg_we_i writes cfg_data_i to limit register cfg_index_i
//   (0 gyro change, 1 gyro offset, 2 accel change, 3 accel offset); write only
//   while no item is in flight.
//   Results are registered in the output buffer. The last sample of each
//   calibration round (every SMOOTH_COUNT+1 samples) waits for the
//   three-step settle check through the merging stage, during which
//   in_stall_o is held high; every other item is taken back to back, one per
//   cycle, while the output buffer is not full.
//   Reset: offsets and filter state clear, limits take their defaults and the
//   unit runs with zero offsets. A full output buffer (output register plus
//   skid register) raises in_stall_o until the receiver drains it.
`default_nettype none

`include "assert_macros.svh"

module imu_bias_calibration_and_correction_unit
  import ibc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [25:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  sample_t     gyro_x_i,
  input  sample_t     gyro_y_i,
  input  sample_t     gyro_z_i,
  input  sample_t     accel_x_i,
  input  sample_t     accel_y_i,
  input  sample_t     accel_z_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  phase_o,
  output sample_t     out_gyro_x_o,
  output sample_t     out_gyro_y_o,
  output sample_t     out_gyro_z_o,
  output sample_t     out_accel_x_o,
  output sample_t     out_accel_y_o,
  output sample_t     out_accel_z_o,
  output sample_t     smooth_accel_x_o,
  output sample_t     smooth_accel_y_o,
  output sample_t     smooth_accel_z_o
);

  typedef enum logic [1:0] {
    MODE_RUN   = 2'd0,
    MODE_WARM  = 2'd1,
    MODE_GYRO  = 2'd2,
    MODE_ACCEL = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    DEC_IDLE = 2'd0,
    DEC_GRAV = 2'd1,
    DEC_DIFF = 2'd2,
    DEC_CMP  = 2'd3
  } dec_e;

  mode_e   mode_q, mode_d;
  dec_e    dec_q, dec_d;
  cnt_t    cnt_q, cnt_d;
  logic    seed_q, seed_d;
  change_t gyro_chg_q;
  sample_t gyro_off_lim_q;
  change_t accel_chg_q;
  sample_t accel_off_lim_q;

  logic       accept;
  logic       push;
  logic       buf_full;
  logic       settled;
  cnt_t       cnt_inc;
  lane_ctrl_t ctrl;
  lane_ctrl_t lane_ctrl [AXES];

  sample_t gyro_in  [AXES];
  sample_t accel_in [AXES];
  sample_t corr_gyro  [AXES];
  sample_t corr_accel [AXES];
  sample_t smooth     [AXES];
  sample_t lane_off   [AXES];
  mag_t    lane_absd  [AXES];

  result_t res_in;
  result_t res_out;

  assign gyro_in[0]  = gyro_x_i;
  assign gyro_in[1]  = gyro_y_i;
  assign gyro_in[2]  = gyro_z_i;
  assign accel_in[0] = accel_x_i;
  assign accel_in[1] = accel_y_i;
  assign accel_in[2] = accel_z_i;

  assign in_stall_o = buf_full || (dec_q != DEC_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign cnt_inc    = cnt_q + 1'b1;

  always_comb begin
    mode_d         = mode_q;
    dec_d          = dec_q;
    cnt_d          = cnt_q;
    seed_d         = seed_q;
    push           = 1'b0;
    ctrl           = '0;
    ctrl.sel_accel = (mode_q == MODE_ACCEL);
    unique case (dec_q)
      DEC_IDLE: begin
        if (accept) begin
          if (op_i == OP_START) begin
            push   = 1'b1;
            cnt_d  = '0;
            seed_d = 1'b0;
            if (WARMUP_COUNT == '0) begin
              ctrl.preset_gyro = 1'b1;
              seed_d           = 1'b1;
              mode_d           = MODE_GYRO;
            end else begin
              mode_d = MODE_WARM;
            end
          end else begin
            unique case (mode_q)
              MODE_WARM: begin
                push = 1'b1;
                if (cnt_inc >= WARMUP_COUNT) begin
                  ctrl.preset_gyro = 1'b1;
                  seed_d           = 1'b1;
                  cnt_d            = '0;
                  mode_d           = MODE_GYRO;
                end else begin
                  cnt_d = cnt_inc;
                end
              end
              MODE_GYRO, MODE_ACCEL: begin
                if (seed_q) begin
                  ctrl.seed = 1'b1;
                  seed_d    = 1'b0;
                  cnt_d     = '0;
                  push      = 1'b1;
                end else begin
                  ctrl.filt = 1'b1;
                  if (cnt_inc < SMOOTH_COUNT) begin
                    cnt_d = cnt_inc;
                    push  = 1'b1;
                  end else begin
                    // round complete, result waits for the settle check
                    cnt_d = '0;
                    dec_d = DEC_GRAV;
                  end
                end
              end
              default: begin
                ctrl.run = 1'b1;
                push     = 1'b1;
              end
            endcase
          end
        end
      end
      DEC_GRAV: begin
        ctrl.grav = (mode_q == MODE_ACCEL);
        dec_d     = DEC_DIFF;
      end
      DEC_DIFF: begin
        ctrl.diff = 1'b1;
        dec_d     = DEC_CMP;
      end
      default: begin
        push   = 1'b1;
        seed_d = 1'b1;
        dec_d  = DEC_IDLE;
        if (settled) begin
          if (mode_q == MODE_GYRO) begin
            ctrl.preset_accel = 1'b1;
            mode_d            = MODE_ACCEL;
          end else begin
            seed_d = 1'b0;
            mode_d = MODE_RUN;
          end
        end
      end
    endcase
  end

  // only the z lane takes gravity
  always_comb begin
    for (int j = 0; j < AXES; j++) begin
      lane_ctrl[j]      = ctrl;
      lane_ctrl[j].grav = ctrl.grav && (j == AXES - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= MODE_RUN;
      dec_q           <= DEC_IDLE;
      cnt_q           <= '0;
      seed_q          <= 1'b0;
      gyro_chg_q      <= CHANGE_W'(4096);
      gyro_off_lim_q  <= SAMPLE_MAX;
      accel_chg_q     <= CHANGE_W'(4096);
      accel_off_lim_q <= SAMPLE_MAX;
    end else begin
      mode_q <= mode_d;
      dec_q  <= dec_d;
      cnt_q  <= cnt_d;
      seed_q <= seed_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_GYRO_CHANGE:  gyro_chg_q      <= cfg_data_i[CHANGE_W-1:0];
          CFG_GYRO_OFFSET:  gyro_off_lim_q  <= cfg_data_i[SAMPLE_W-1:0];
          CFG_ACCEL_CHANGE: accel_chg_q     <= cfg_data_i[CHANGE_W-1:0];
          CFG_ACCEL_OFFSET: accel_off_lim_q <= cfg_data_i[SAMPLE_W-1:0];
        endcase
      end
    end
  end

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    ibc_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (lane_ctrl[g]),
      .gyro_i       (gyro_in[g]),
      .accel_i      (accel_in[g]),
      .corr_gyro_o  (corr_gyro[g]),
      .corr_accel_o (corr_accel[g]),
      .smooth_o     (smooth[g]),
      .offset_o     (lane_off[g]),
      .abs_diff_o   (lane_absd[g])
    );
  end

  ibc_merge u_merge (
    .clk_i        (clk_i),
    .capture_i    (ctrl.diff),
    .abs_diff_i   (lane_absd),
    .offset_i     (lane_off),
    .change_lim_i ((mode_q == MODE_ACCEL) ? accel_chg_q : gyro_chg_q),
    .offset_lim_i ((mode_q == MODE_ACCEL) ? accel_off_lim_q : gyro_off_lim_q),
    .settled_o    (settled)
  );

  always_comb begin
    res_in.phase = mode_d;
    for (int j = 0; j < AXES; j++) begin
      res_in.gyro[j]   = corr_gyro[j];
      res_in.accel[j]  = corr_accel[j];
      res_in.smooth[j] = smooth[j];
    end
  end

  ibc_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res_in),
    .stall_i (out_stall_i),
    .valid_o (out_valid_o),
    .full_o  (buf_full),
    .data_o  (res_out)
  );

  assign phase_o          = res_out.phase;
  assign out_gyro_x_o     = res_out.gyro[0];
  assign out_gyro_y_o     = res_out.gyro[1];
  assign out_gyro_z_o     = res_out.gyro[2];
  assign out_accel_x_o    = res_out.accel[0];
  assign out_accel_y_o    = res_out.accel[1];
  assign out_accel_z_o    = res_out.accel[2];
  assign smooth_accel_x_o = res_out.smooth[0];
  assign smooth_accel_y_o = res_out.smooth[1];
  assign smooth_accel_z_o = res_out.smooth[2];

  `IBC_ASSERT(a_settle_len, clk_i, rst_ni, (dec_q == DEC_GRAV) |-> ##2 push)
  `IBC_ASSERT(a_no_seed_idle, clk_i, rst_ni, (mode_q == MODE_RUN || mode_q == MODE_WARM) |-> !seed_q)
  `IBC_ASSERT(a_warm_cnt, clk_i, rst_ni, (mode_q == MODE_WARM) |-> (cnt_q < WARMUP_COUNT))
  `IBC_ASSERT(a_cal_cnt, clk_i, rst_ni, (mode_q == MODE_GYRO || mode_q == MODE_ACCEL) |-> (cnt_q < SMOOTH_COUNT))

endmodule

`default_nettype wire
